FILE: rtl/x86_integer_alu_with_flags_unit_assert.svh
// Assertion macros shared by the ALU block.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_UNIT_ASSERT_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_UNIT_ASSERT_SVH

// Assert that a property implication holds when out of reset.
`define XALU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert a next-cycle implication.
`define XALU_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/xalu_pkg.sv
package xalu_pkg;

  typedef enum logic [4:0] {
    ACT_ADD  = 5'd0,
    ACT_ADC  = 5'd1,
    ACT_SUB  = 5'd2,
    ACT_SBB  = 5'd3,
    ACT_MUL  = 5'd4,
    ACT_IMUL = 5'd5,
    ACT_DIV  = 5'd6,
    ACT_IDIV = 5'd7,
    ACT_MOD  = 5'd8,
    ACT_IMOD = 5'd9,
    ACT_AND  = 5'd10,
    ACT_XOR  = 5'd11,
    ACT_OR   = 5'd12,
    ACT_SHL  = 5'd13,
    ACT_SHR  = 5'd14,
    ACT_SAR  = 5'd15,
    ACT_SAL  = 5'd16
  } act_t;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;

  localparam logic [4:0] COUNT_MASK = 5'h1f;
  localparam int unsigned DIV_STEPS = 64;

  // Flags in the kept register: bit 0 CF, 1 OF, 2 ZF, 3 SF, 4 PF.
  typedef struct packed {
    logic pf;
    logic sf;
    logic zf;
    logic of;
    logic cf;
  } flags_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture item for the check cycle
    logic div_start; // begin division
    logic div_step;  // one restoring step
    logic div_fin;   // fix signs, produce result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_div;  // loaded item needs the divider
    logic div_err; // division error found for the loaded item
    logic div_last;
  } dp_sts_t;

endpackage

FILE: rtl/xalu_ctrl.sv
module xalu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output xalu_pkg::dp_cmd_t cmd,
  input  xalu_pkg::dp_sts_t sts
);
  import xalu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;

  // Output register frees up when taken, so a new item can enter alongside.
  assign in_tready  = (state_r == ST_IDLE) && (!ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;

  always_comb begin
    state_nxt = state_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.load = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.is_div || sts.div_err) begin
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.div_fin = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

FILE: rtl/xalu_dp.sv
module xalu_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [4:0]        in_action,
  input  logic [31:0]       in_src,
  input  logic [63:0]       in_dest,
  input  logic [1:0]        in_size,
  input  xalu_pkg::dp_cmd_t cmd,
  output xalu_pkg::dp_sts_t sts,
  output logic [63:0]       res_o,
  output xalu_pkg::flags_t  flags_o,
  output logic              derr_o
);
  import xalu_pkg::*;

  // Captured item.
  logic [4:0]  act_r;
  logic [31:0] src_r;
  logic [63:0] dest_r;
  logic [1:0]  size_r;

  flags_t      flags_r, flags_nxt;
  logic [63:0] res_r, res_nxt;
  logic        derr_r, derr_nxt;

  // Divider state.
  logic [63:0] quo_r;
  logic [64:0] rem_r;
  logic [31:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        neg_q_r, neg_r_r;

  // Non-divide operations, evaluated in the check cycle from captured item.
  logic [5:0]  w;
  logic [63:0] mask, sign, a, b, sa, sb, cin;
  logic [64:0] sum, dif;
  logic [63:0] prod, sres, wide, rsh;
  logic [4:0]  n;
  logic        zf_v, sf_v, pf_v, ov;
  logic [63:0] dvs_ext, abs_n, abs_d;
  logic        nn, dn, zero_d, s_ovf, is_sdiv;

  always_comb begin
    unique case (size_r)
      SIZE_8:  w = 6'd8;
      SIZE_16: w = 6'd16;
      default: w = 6'd32;
    endcase
    mask = (64'd1 << w) - 64'd1;
    sign = 64'd1 << (w - 6'd1);
    a    = dest_r & mask;
    b    = {32'd0, src_r} & mask;
    sa   = ((a & sign) != 64'd0) ? (a | ~mask) : a;
    sb   = ((b & sign) != 64'd0) ? (b | ~mask) : b;
    cin  = {63'd0, flags_r.cf};
    n    = src_r[4:0] & COUNT_MASK;
    sum  = {1'b0, a} + {1'b0, b} + ((act_r == ACT_ADC) ? {1'b0, cin} : 65'd0);
    dif  = {1'b0, a} - {1'b0, b} - ((act_r == ACT_SBB) ? {1'b0, cin} : 65'd0);
    prod = 64'd0;
    wide = a << n;
    rsh  = 64'd0;
    nn = dest_r[63];
    dn = src_r[31];
    dvs_ext = {{32{src_r[31]}}, src_r};
    abs_n = nn ? (64'd0 - dest_r) : dest_r;
    abs_d = dn ? (64'd0 - dvs_ext) : dvs_ext;
    is_sdiv = (act_r == ACT_IDIV) || (act_r == ACT_IMOD);
    zero_d = (src_r == 32'd0);
    s_ovf = is_sdiv && (dest_r == 64'h8000_0000_0000_0000) && (src_r == 32'hffff_ffff);
    sres = 64'd0;
    flags_nxt = flags_r;
    ov = 1'b0;
    unique case (act_r)
      ACT_ADD, ACT_ADC: begin
        sres = sum[63:0] & mask;
        flags_nxt.cf = sum[w];
        flags_nxt.of = ((~(a ^ b) & (a ^ sres) & sign) != 64'd0);
      end
      ACT_SUB, ACT_SBB: begin
        sres = dif[63:0] & mask;
        flags_nxt.cf = dif[64];
        flags_nxt.of = (((a ^ b) & (a ^ sres) & sign) != 64'd0);
      end
      ACT_MUL: begin
        prod = a[31:0] * b[31:0];
        sres = prod;
        ov = ((prod & ~mask) != 64'd0);
        flags_nxt.cf = ov;
        flags_nxt.of = ov;
      end
      ACT_IMUL: begin
        // Both operands are signed, so they widen by sign to the 64-bit product.
        prod = $signed(sa[31:0]) * $signed(sb[31:0]);
        sres = prod;
        ov = (((prod & sign) != 64'd0) ? ((prod | mask) != 64'hffff_ffff_ffff_ffff)
                                       : ((prod & ~mask) != 64'd0));
        flags_nxt.cf = ov;
        flags_nxt.of = ov;
      end
      ACT_AND, ACT_XOR, ACT_OR: begin
        sres = (act_r == ACT_AND) ? (a & b) : ((act_r == ACT_XOR) ? (a ^ b) : (a | b));
        flags_nxt.cf = 1'b0;
        flags_nxt.of = 1'b0;
      end
      ACT_SHL, ACT_SAL: begin
        sres = wide & mask;
        if (n != 5'd0) flags_nxt.cf = wide[w];
        else sres = a;
      end
      ACT_SHR: begin
        rsh = a >> (n - 5'd1);
        sres = (n != 5'd0) ? ((rsh >> 1) & mask) : a;
        if (n != 5'd0) flags_nxt.cf = rsh[0];
      end
      ACT_SAR: begin
        rsh = 64'($signed(sa) >>> (n - 5'd1));
        sres = (n != 5'd0) ? (64'($signed(rsh) >>> 1) & mask) : a;
        if (n != 5'd0) flags_nxt.cf = rsh[0];
      end
      default: sres = 64'd0;
    endcase
    zf_v = (sres == 64'd0);
    sf_v = ((sres & sign) != 64'd0);
    pf_v = ~^sres[7:0];
    unique case (act_r)
      ACT_ADD, ACT_ADC, ACT_SUB, ACT_SBB, ACT_AND, ACT_XOR, ACT_OR: begin
        flags_nxt.zf = zf_v; flags_nxt.sf = sf_v; flags_nxt.pf = pf_v;
      end
      ACT_SHL, ACT_SAL, ACT_SHR, ACT_SAR: begin
        if (n != 5'd0) begin
          flags_nxt.zf = zf_v; flags_nxt.sf = sf_v; flags_nxt.pf = pf_v;
        end
      end
      default: ;
    endcase
  end

  assign sts.is_div = (act_r == ACT_DIV) || (act_r == ACT_MOD) || is_sdiv;
  assign sts.div_err = zero_d || s_ovf;
  assign sts.div_last = (cnt_r == 6'(DIV_STEPS - 1));

  // One restoring step: shift in next dividend bit, subtract if it fits.
  logic [64:0] rem_sh, rem_sub;
  logic [63:0] qv, rv, fin;
  always_comb begin
    rem_sh  = {rem_r[63:0], quo_r[63]};
    rem_sub = rem_sh - {33'd0, dvs_r};
    qv = neg_q_r ? (64'd0 - quo_r) : quo_r;
    rv = neg_r_r ? (64'd0 - rem_r[63:0]) : rem_r[63:0];
    fin = ((act_r == ACT_DIV) || (act_r == ACT_IDIV)) ? {32'd0, qv[31:0]}
                                                        : {32'd0, rv[31:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      src_r  <= in_src;
      dest_r <= in_dest;
      size_r <= in_size;
    end
    if (cmd.div_start) begin
      cnt_r   <= 6'd0;
      rem_r   <= 65'd0;
      quo_r   <= is_sdiv ? abs_n : dest_r;
      dvs_r   <= is_sdiv ? abs_d[31:0] : src_r;
      neg_q_r <= is_sdiv && (nn != dn);
      neg_r_r <= is_sdiv && nn;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 6'd1;
      if (!rem_sub[64]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[62:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[62:0], 1'b0};
      end
    end
    res_r  <= res_nxt;
    derr_r <= derr_nxt;
  end

  always_comb begin
    res_nxt  = res_r;
    derr_nxt = derr_r;
    if (cmd.div_fin) begin
      res_nxt = fin;
      derr_nxt = 1'b0;
    end else if (cmd.div_start) begin
      res_nxt = res_r;
    end else if (!cmd.div_step && !cmd.load && sts.is_div == 1'b0) begin
      res_nxt = res_r;
    end
  end

  // Check cycle: the cycle after load. Marked by a flag.
  logic chk_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      chk_r   <= 1'b0;
    end else begin
      chk_r <= cmd.load;
      if (chk_r && !sts.is_div) flags_r <= flags_nxt;
    end
  end

  // Final registered result for the check cycle overrides the hold path.
  logic [63:0] out_res_r;
  logic        out_derr_r;
  always_ff @(posedge clk) begin
    if (chk_r) begin
      out_res_r  <= sts.is_div ? 64'd0 : sres;
      out_derr_r <= sts.is_div && sts.div_err;
    end else if (cmd.div_fin) begin
      out_res_r  <= res_nxt;
      out_derr_r <= derr_nxt;
    end
  end

  assign res_o   = out_res_r;
  assign derr_o  = out_derr_r;
  assign flags_o = flags_r;

endmodule

FILE: rtl/x86_integer_alu_with_flags_unit.sv
// Channel | Ports                          | Contents
// input   | in_tvalid/in_tready/in_tdata   | action, src_value, dest_value, size_code
// output  | out_tvalid/out_tready/out_tdata| result plus the five flags, divide_error
//
// Most operations capture the item, then compute it in the check state into the
// output register. Division and modulo run through the 64-step restoring
// divider, one quotient bit per cycle; a zero divisor or a signed quotient
// overflow is found in the check state and returns from there.
// Reset (rst_n low, synchronous) clears the state machine and all kept flags.
// A stalled output holds; the next item is taken once the output is free or
// is being taken in the same cycle.
module x86_integer_alu_with_flags_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [4:0] action, [36:5] src_value, [100:37] dest_value, [102:101] size_code
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [63:0] result, [64] carry, [65] overflow, [66] zero, [67] sign,
  // [68] parity, [69] divide_error
  output logic [71:0]  out_tdata
);
  import xalu_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [63:0] res;
  flags_t      flags;
  logic        derr;

  xalu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .cmd(cmd), .sts(sts)
  );

  xalu_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_action(in_tdata[4:0]), .in_src(in_tdata[36:5]),
    .in_dest(in_tdata[100:37]), .in_size(in_tdata[102:101]),
    .cmd(cmd), .sts(sts), .res_o(res), .flags_o(flags), .derr_o(derr)
  );

  // The output register holds until taken, so flags shown follow the item.
  assign out_tdata = {2'b00, derr, flags.pf, flags.sf, flags.zf, flags.of,
                      flags.cf, res};

`include "x86_integer_alu_with_flags_unit_assert.svh"

  `XALU_ASSERT_IMP(a_no_accept_busy, in_tvalid && in_tready, !(out_tvalid && !out_tready))
  `XALU_ASSERT_NXT(a_load_once, cmd.load, !cmd.load)
  `XALU_ASSERT_IMP(a_cmd_excl, cmd.div_step, !cmd.load && !cmd.div_fin)

endmodule
